### design/rmed_pkg.sv
// shared types, constants and compare-exchange helper for the rgb 3x3 median block
package rmed_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 12;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int NB         = 8;
  localparam int NUM_CELLS  = NB / 2;
  localparam int MED_IDX    = 3;
  localparam int WIN_SIZE   = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int FW_RESET   = 640;
  localparam int FH_RESET   = 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [CH_W-1:0] pix_blue;
    logic [CH_W-1:0] pix_green;
    logic [CH_W-1:0] pix_red;
    logic            frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0]  out_blue;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_red;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             frame_done;
  } res_out_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } px_t;

  typedef logic [NB-1:0][CH_W-1:0] nb_vec_t;

  typedef struct packed {
    nb_vec_t          blue;
    nb_vec_t          green;
    nb_vec_t          red;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } sort_item_t;

  // one layer of odd-even transposition: even pairs when odd is 0, odd pairs otherwise
  function automatic nb_vec_t cx_layer(nb_vec_t v, logic odd);
    nb_vec_t r;
    r = v;
    for (int i = 0; i < NB - 1; i++) begin
      if (((i % 2) == int'(odd)) && (v[i] > v[i+1])) begin
        r[i]   = v[i+1];
        r[i+1] = v[i];
      end
    end
    return r;
  endfunction

endpackage

### design/rmed_ram.sv
// generic single-write, single-read ram with registered read data
module rmed_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/rmed_sort_cell.sv
// one sorter cell: an even and an odd compare-exchange layer on all three channels
module rmed_sort_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  rmed_pkg::sort_item_t in_item,
  output logic                out_valid,
  output rmed_pkg::sort_item_t out_item
);

  rmed_pkg::sort_item_t item_next;

  always_comb begin
    item_next       = in_item;
    item_next.blue  = rmed_pkg::cx_layer(rmed_pkg::cx_layer(in_item.blue, 1'b0), 1'b1);
    item_next.green = rmed_pkg::cx_layer(rmed_pkg::cx_layer(in_item.green, 1'b0), 1'b1);
    item_next.red   = rmed_pkg::cx_layer(rmed_pkg::cx_layer(in_item.red, 1'b0), 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule

### design/rgb_median_3x3_centre_excluded_core.sv
// top level: line buffers, 3x3 window, sorter cell chain and output skid stage
//
// Takes one RGB pixel per clock in raster order and, for every interior pixel,
// gives per channel the fourth smallest of the eight neighbours (centre left out).
// Border pixels give no result. A pixel is accepted every cycle that pix_ready is
// high; pix_ready drops only when both the result register and the skid register
// hold results not yet taken. For the pixel that completes a window, the accepting
// edge loads the line-buffer read stage; the window then passes four sorter cells in
// a row, each doing an even and an odd compare-exchange layer, and then the result
// register. The two line buffers are rams of MAX_WIDTH entries with one write and
// one registered read each, and need no clearing after reset.
// Configuration writes are taken in any cycle (cfg_ready is always high) but should
// be made while the block is idle.
module rgb_median_3x3_centre_excluded_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pix_valid,
  output logic                                pix_ready,
  input  rmed_pkg::pix_in_t                   pix,
  output logic                                res_valid,
  input  logic                                res_ready,
  output rmed_pkg::res_out_t                  res,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rmed_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rmed_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration
  logic [rmed_pkg::FW_W-1:0] frame_width;
  logic [rmed_pkg::FH_W-1:0] frame_height;
  logic [rmed_pkg::FW_W-1:0] w_eff;
  logic [rmed_pkg::FH_W-1:0] h_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= rmed_pkg::FW_W'(rmed_pkg::FW_RESET);
      frame_height <= rmed_pkg::FH_W'(rmed_pkg::FH_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        rmed_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[rmed_pkg::FW_W-1:0];
        rmed_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[rmed_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width < rmed_pkg::FW_W'(rmed_pkg::MIN_DIM)) begin
      w_eff = rmed_pkg::FW_W'(rmed_pkg::MIN_DIM);
    end else if (frame_width > rmed_pkg::FW_W'(rmed_pkg::MAX_WIDTH)) begin
      w_eff = rmed_pkg::FW_W'(rmed_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height < rmed_pkg::FH_W'(rmed_pkg::MIN_DIM)) begin
      h_eff = rmed_pkg::FH_W'(rmed_pkg::MIN_DIM);
    end else if (frame_height > rmed_pkg::FH_W'(rmed_pkg::MAX_HEIGHT)) begin
      h_eff = rmed_pkg::FH_W'(rmed_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
  end

  // handshake and pipeline enable
  logic en;
  logic acc;
  logic skid_valid;

  assign en        = !skid_valid;
  assign pix_ready = en;
  assign acc       = pix_valid && pix_ready;

  // position counters
  logic [rmed_pkg::COL_W-1:0] col_count;
  logic [rmed_pkg::ROW_W-1:0] row_count;
  logic [rmed_pkg::COL_W-1:0] col0, cur_col, col_count_next;
  logic [rmed_pkg::ROW_W-1:0] row0, cur_row, row_count_next;
  logic [rmed_pkg::FH_W-1:0]  row1, row_inc;
  logic [rmed_pkg::FW_W-1:0]  col_inc;
  logic                       col_wrap, end_row, has_res, last_pix;

  always_comb begin
    col0     = pix.frame_start ? '0 : col_count;
    row0     = pix.frame_start ? '0 : row_count;
    // pending position may lie beyond a shrunk frame
    col_wrap = {1'b0, col0} >= w_eff;
    cur_col  = col_wrap ? '0 : col0;
    row1     = {1'b0, row0} + rmed_pkg::FH_W'(col_wrap);
    cur_row  = (row1 >= h_eff) ? '0 : row1[rmed_pkg::ROW_W-1:0];

    col_inc  = {1'b0, cur_col} + rmed_pkg::FW_W'(1);
    row_inc  = {1'b0, cur_row} + rmed_pkg::FH_W'(1);
    end_row  = col_inc >= w_eff;
    if (end_row) begin
      col_count_next = '0;
      row_count_next = (row_inc >= h_eff) ? '0 : row_inc[rmed_pkg::ROW_W-1:0];
    end else begin
      col_count_next = col_inc[rmed_pkg::COL_W-1:0];
      row_count_next = cur_row;
    end

    has_res  = (cur_row >= rmed_pkg::ROW_W'(2)) && (cur_col >= rmed_pkg::COL_W'(2));
    last_pix = ({1'b0, cur_row} == h_eff - rmed_pkg::FH_W'(1))
            && ({1'b0, cur_col} == w_eff - rmed_pkg::FW_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (acc) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  // line buffer read stage
  logic                       s1_valid;
  logic                       s1_res;
  logic                       s1_done;
  logic [rmed_pkg::COL_W-1:0] s1_col;
  logic [rmed_pkg::ROW_W-1:0] s1_row;
  rmed_pkg::px_t              s1_pix;
  rmed_pkg::px_t              up_rd, mid_rd, top1, mid1, px_in;
  logic                       s1_adv;
  logic                       fwd_hit;
  rmed_pkg::px_t              fwd_top, fwd_mid;

  assign px_in.blue  = pix.pix_blue;
  assign px_in.green = pix.pix_green;
  assign px_in.red   = pix.pix_red;

  assign s1_adv = en && s1_valid;

  // a read that hits the address written in the same cycle takes the new data
  assign top1 = fwd_hit ? fwd_top : up_rd;
  assign mid1 = fwd_hit ? fwd_mid : mid_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix  <= px_in;
      s1_col  <= cur_col;
      s1_row  <= cur_row - rmed_pkg::ROW_W'(1);
      s1_res  <= has_res;
      s1_done <= last_pix;
      fwd_hit <= s1_valid && (s1_col == cur_col);
      fwd_top <= mid1;
      fwd_mid <= s1_pix;
    end
  end

  rmed_ram #(
    .WIDTH (rmed_pkg::PIX_W),
    .DEPTH (rmed_pkg::MAX_WIDTH)
  ) u_upper_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (mid1),
    .re    (acc),
    .raddr (cur_col),
    .rdata (up_rd)
  );

  rmed_ram #(
    .WIDTH (rmed_pkg::PIX_W),
    .DEPTH (rmed_pkg::MAX_WIDTH)
  ) u_middle_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (s1_pix),
    .re    (acc),
    .raddr (cur_col),
    .rdata (mid_rd)
  );

  // 3x3 window, column 2 is the newest
  rmed_pkg::px_t win [rmed_pkg::WIN_SIZE];
  rmed_pkg::px_t win_next [rmed_pkg::WIN_SIZE];

  always_comb begin
    win_next[0] = win[1];
    win_next[1] = win[2];
    win_next[2] = top1;
    win_next[3] = win[4];
    win_next[4] = win[5];
    win_next[5] = mid1;
    win_next[6] = win[7];
    win_next[7] = win[8];
    win_next[8] = s1_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rmed_pkg::WIN_SIZE; i++) begin
        win[i] <= '0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < rmed_pkg::WIN_SIZE; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

  // sorter cell chain
  rmed_pkg::sort_item_t cell_item  [rmed_pkg::NUM_CELLS+1];
  logic                 cell_valid [rmed_pkg::NUM_CELLS+1];

  always_comb begin
    cell_valid[0]     = s1_valid && s1_res;
    cell_item[0].row  = s1_row;
    cell_item[0].col  = s1_col - rmed_pkg::COL_W'(1);
    cell_item[0].done = s1_done;
    for (int j = 0; j < rmed_pkg::NB; j++) begin
      // skip the centre of the window
      cell_item[0].blue[j]  = win_next[(j < 4) ? j : j + 1].blue;
      cell_item[0].green[j] = win_next[(j < 4) ? j : j + 1].green;
      cell_item[0].red[j]   = win_next[(j < 4) ? j : j + 1].red;
    end
  end

  for (genvar g = 0; g < rmed_pkg::NUM_CELLS; g++) begin : g_cell
    rmed_sort_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cell_valid[g]),
      .in_item   (cell_item[g]),
      .out_valid (cell_valid[g+1]),
      .out_item  (cell_item[g+1])
    );
  end

  // result register with skid
  rmed_pkg::res_out_t push_data;
  rmed_pkg::res_out_t skid_data;
  logic               push, pop;

  always_comb begin
    push_data.out_blue   = cell_item[rmed_pkg::NUM_CELLS].blue[rmed_pkg::MED_IDX];
    push_data.out_green  = cell_item[rmed_pkg::NUM_CELLS].green[rmed_pkg::MED_IDX];
    push_data.out_red    = cell_item[rmed_pkg::NUM_CELLS].red[rmed_pkg::MED_IDX];
    push_data.out_row    = cell_item[rmed_pkg::NUM_CELLS].row;
    push_data.out_col    = cell_item[rmed_pkg::NUM_CELLS].col;
    push_data.frame_done = cell_item[rmed_pkg::NUM_CELLS].done;
  end

  assign push = en && cell_valid[rmed_pkg::NUM_CELLS];
  assign pop  = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || pop) begin
      res_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || pop) begin
      res <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

`ifndef SYNTHESIS
  // a beat waits in the skid register only behind a pending result
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> res_valid)
    else $error("skid holds a beat while result register is empty");

  // results are interior pixels only
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.out_row != '0) && (res.out_col != '0))
    else $error("result beat on a border position");

  // same-address read and write must select the forwarded data
  assert property (@(posedge clk) disable iff (rst)
    (acc && s1_valid && (s1_col == cur_col)) |=> fwd_hit)
    else $error("line buffer forwarding missed");

  // a result never appears from nothing
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cell_valid[rmed_pkg::NUM_CELLS]))
    else $error("result beat without a sorter output");
`endif

endmodule

### sim/rgb_median_3x3_centre_excluded_core_tb.sv
// testbench for the rgb 3x3 median core: directed table, random frames, own median predictor
`timescale 1ns / 100ps

module rgb_median_3x3_centre_excluded_core_tb;

  localparam int          DRAIN_SETTLE = 16;
  localparam int          PHASE_ITEMS  = 360;
  localparam int          EDGE_ITEMS   = 40;
  localparam int          DIR_ROWS     = 22;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  // indexes with no register behind them
  localparam logic [rmed_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [rmed_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    rmed_pkg::pix_in_t  px;
    logic               typed;
    rmed_pkg::res_out_t want;
  } dir_row_t;

  logic                            clk;
  logic                            rst       = 1'b1;
  logic                            pix_valid = 1'b0;
  logic                            pix_ready;
  rmed_pkg::pix_in_t               pix       = '0;
  logic                            res_valid;
  logic                            res_ready = 1'b0;
  rmed_pkg::res_out_t              res;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [rmed_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rmed_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  int          fail_count     = 0;
  int          pixels_sent    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int unsigned cycle_count    = 0;

  // predictor state
  logic [rmed_pkg::FW_W-1:0] size_width  = rmed_pkg::FW_W'(rmed_pkg::FW_RESET);
  logic [rmed_pkg::FH_W-1:0] size_height = rmed_pkg::FH_W'(rmed_pkg::FH_RESET);
  rmed_pkg::px_t             line_top [rmed_pkg::MAX_WIDTH];
  rmed_pkg::px_t             line_mid [rmed_pkg::MAX_WIDTH];
  rmed_pkg::px_t             win [rmed_pkg::WIN_SIZE];
  int unsigned               col_pos = 0;
  int unsigned               row_pos = 0;

  rmed_pkg::res_out_t median_expected [$];
  dir_row_t           dir_table [DIR_ROWS];

  rgb_median_3x3_centre_excluded_core u_top (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // k-th order statistic: smallest value that has at least k values at or below it
  function automatic logic [rmed_pkg::CH_W-1:0] fourth_smallest(
    input logic [rmed_pkg::NB*rmed_pkg::CH_W-1:0] nb
  );
    logic [rmed_pkg::CH_W-1:0] v [rmed_pkg::NB];
    logic [rmed_pkg::CH_W-1:0] best;
    int i, j, cnt;
    best = '1;
    for (i = 0; i < rmed_pkg::NB; i++) v[i] = nb[i*rmed_pkg::CH_W +: rmed_pkg::CH_W];
    for (i = 0; i < rmed_pkg::NB; i++) begin
      cnt = 0;
      for (j = 0; j < rmed_pkg::NB; j++) if (v[j] <= v[i]) cnt++;
      if (cnt >= rmed_pkg::MED_IDX + 1 && v[i] < best) best = v[i];
    end
    return best;
  endfunction

  task automatic median_predict(input rmed_pkg::pix_in_t px, output bit hit,
                                output rmed_pkg::res_out_t r);
    int unsigned w, h, c, rw;
    int i, k, n;
    rmed_pkg::px_t cur;
    logic [rmed_pkg::NB*rmed_pkg::CH_W-1:0] nb_b, nb_g, nb_r;
    w = (size_width < rmed_pkg::MIN_DIM) ? rmed_pkg::MIN_DIM :
        (size_width > rmed_pkg::MAX_WIDTH) ? rmed_pkg::MAX_WIDTH : size_width;
    h = (size_height < rmed_pkg::MIN_DIM) ? rmed_pkg::MIN_DIM :
        (size_height > rmed_pkg::MAX_HEIGHT) ? rmed_pkg::MAX_HEIGHT : size_height;
    cur.blue  = px.pix_blue;
    cur.green = px.pix_green;
    cur.red   = px.pix_red;
    if (px.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    // a shrunk size can leave the position outside the frame
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c  = col_pos;
    rw = row_pos;
    for (k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = line_top[c];
    win[5] = line_mid[c];
    win[8] = cur;
    line_top[c] = line_mid[c];
    line_mid[c] = cur;
    r   = '0;
    hit = (rw >= 2) && (c >= 2);
    if (hit) begin
      n = 0;
      for (i = 0; i < rmed_pkg::WIN_SIZE; i++) begin
        if (i != 4) begin
          nb_b[n*rmed_pkg::CH_W +: rmed_pkg::CH_W] = win[i].blue;
          nb_g[n*rmed_pkg::CH_W +: rmed_pkg::CH_W] = win[i].green;
          nb_r[n*rmed_pkg::CH_W +: rmed_pkg::CH_W] = win[i].red;
          n++;
        end
      end
      r.out_blue   = fourth_smallest(nb_b);
      r.out_green  = fourth_smallest(nb_g);
      r.out_red    = fourth_smallest(nb_r);
      r.out_row    = rmed_pkg::ROW_W'(rw - 1);
      r.out_col    = rmed_pkg::COL_W'(c - 1);
      r.frame_done = (rw == h - 1) && (c == w - 1);
    end
    col_pos = c + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = rw + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  function automatic logic [rmed_pkg::CH_W-1:0] rand_channel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return rmed_pkg::CH_W'($urandom_range(0, 3) * 85);  // few levels, lots of ties
      default: return rmed_pkg::CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic rmed_pkg::pix_in_t rand_pixel(input bit fs);
    rmed_pkg::pix_in_t p;
    p.pix_blue    = rand_channel();
    p.pix_green   = rand_channel();
    p.pix_red     = rand_channel();
    p.frame_start = fs;
    return p;
  endfunction

  function automatic dir_row_t plain_row(input logic [rmed_pkg::CH_W-1:0] b, g, rd,
                                         input logic fs);
    dir_row_t t;
    t = '0;
    t.px.pix_blue    = b;
    t.px.pix_green   = g;
    t.px.pix_red     = rd;
    t.px.frame_start = fs;
    return t;
  endfunction

  // entered and left just after a falling edge
  task automatic push_pixel(input rmed_pkg::pix_in_t px, input bit typed,
                            input rmed_pkg::res_out_t want);
    bit hit;
    rmed_pkg::res_out_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix       <= px;
    @(posedge clk);
    while (pix_ready !== 1'b1) @(posedge clk);
    median_predict(px, hit, got);
    if (typed) median_expected.push_back(want);
    else if (hit) median_expected.push_back(got);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    pix_valid <= 1'b0;
    while (median_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [rmed_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rmed_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    if (idx == rmed_pkg::CFG_FRAME_WIDTH) size_width = data[rmed_pkg::FW_W-1:0];
    else if (idx == rmed_pkg::CFG_FRAME_HEIGHT) size_height = data[rmed_pkg::FH_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // frame_len 0: no frame start after the first beat
  task automatic send_stream(input int n, input int frame_len, input bit start_new);
    int i;
    bit fs;
    for (i = 0; i < n; i++) begin
      if (i == 0) fs = start_new;
      else if (frame_len == 0) fs = 1'b0;
      else if (i % frame_len == 0) fs = ($urandom_range(0, 7) != 0);
      else fs = ($urandom_range(0, 63) == 0);
      push_pixel(rand_pixel(fs), 1'b0, '0);
      if ($urandom_range(0, 399) == 0) wait_results_drained();
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(negedge clk) res_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (!rst && res_valid === 1'b1 && res_ready) begin
      if (median_expected.size() == 0) begin
        $error("result beat with nothing expected: row %0d col %0d", res.out_row, res.out_col);
        fail_count++;
      end else begin
        rmed_pkg::res_out_t want;
        want = median_expected.pop_front();
        check_field("out_blue", 16'(want.out_blue), 16'(res.out_blue));
        check_field("out_green", 16'(want.out_green), 16'(res.out_green));
        check_field("out_red", 16'(want.out_red), 16'(res.out_red));
        check_field("out_row", 16'(want.out_row), 16'(res.out_row));
        check_field("out_col", 16'(want.out_col), 16'(res.out_col));
        check_field("frame_done", 16'(want.frame_done), 16'(res.frame_done));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int i, phase, phase_start, w_eff, h_eff;
    logic [rmed_pkg::FW_W-1:0] w_val;
    logic [rmed_pkg::FH_W-1:0] h_val;
    logic                      b12;

    for (i = 0; i < rmed_pkg::WIN_SIZE; i++) win[i] = '0;

    // partial frame, then a restart mid-frame into a white window with a black centre,
    // then a black window with a white centre reached by the natural wrap
    dir_table[0] = plain_row(8'd12, 8'd200, 8'd77, 1'b1);
    dir_table[1] = plain_row(8'd255, 8'd0, 8'd128, 1'b0);
    dir_table[2] = plain_row(8'd1, 8'd254, 8'd100, 1'b0);
    dir_table[3] = plain_row(8'd0, 8'd255, 8'd3, 1'b0);
    for (i = 0; i < 9; i++) begin
      dir_table[4+i]  = (i == 4) ? plain_row(8'd0, 8'd0, 8'd0, 1'b0)
                                 : plain_row(8'd255, 8'd255, 8'd255, i == 0);
      dir_table[13+i] = (i == 4) ? plain_row(8'd255, 8'd255, 8'd255, 1'b0)
                                 : plain_row(8'd0, 8'd0, 8'd0, 1'b0);
    end
    dir_table[12].typed = 1'b1;
    dir_table[12].want  = '{out_blue: 8'd255, out_green: 8'd255, out_red: 8'd255,
                            out_row: 12'd1, out_col: 11'd1, frame_done: 1'b1};
    dir_table[21].typed = 1'b1;
    dir_table[21].want  = '{out_blue: 8'd0, out_green: 8'd0, out_red: 8'd0,
                            out_row: 12'd1, out_col: 11'd1, frame_done: 1'b1};

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    cfg_write(rmed_pkg::CFG_FRAME_WIDTH, 13'd3);
    cfg_write(rmed_pkg::CFG_FRAME_HEIGHT, 13'd3);
    for (i = 0; i < DIR_ROWS; i++) begin
      push_pixel(dir_table[i].px, dir_table[i].typed, dir_table[i].want);
    end

    // shrink the frame under a running position: column wraps first, then the row
    wait_results_drained();
    cfg_write(rmed_pkg::CFG_FRAME_WIDTH, 13'd10);
    cfg_write(rmed_pkg::CFG_FRAME_HEIGHT, 13'd8);
    send_stream(37, 0, 1'b1);
    wait_results_drained();
    cfg_write(rmed_pkg::CFG_FRAME_WIDTH, 13'd5);
    send_stream(12, 0, 1'b0);
    wait_results_drained();
    cfg_write(rmed_pkg::CFG_FRAME_HEIGHT, 13'd3);
    send_stream(20, 0, 1'b0);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      phase_start = pixels_sent;
      while (pixels_sent - phase_start < PHASE_ITEMS) begin
        wait_results_drained();
        w_val = rmed_pkg::FW_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                             : $urandom_range(3, 12));
        h_val = rmed_pkg::FH_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 2)
                                                             : $urandom_range(3, 7));
        b12   = 1'($urandom_range(0, 1));
        cfg_write(rmed_pkg::CFG_FRAME_WIDTH, {b12, w_val});
        cfg_write(rmed_pkg::CFG_FRAME_HEIGHT, h_val);
        if ($urandom_range(0, 3) == 0)
          cfg_write($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                    rmed_pkg::CFG_DATA_W'($urandom_range(0, 8191)));
        w_eff = (w_val < rmed_pkg::MIN_DIM) ? rmed_pkg::MIN_DIM : w_val;
        h_eff = (h_val < rmed_pkg::MIN_DIM) ? rmed_pkg::MIN_DIM : h_val;
        send_stream($urandom_range(1, 3) * w_eff * h_eff + $urandom_range(0, w_eff * h_eff - 1),
                    w_eff * h_eff, 1'b1);
      end
    end

    // oversized width and zero height saturate, then a width write with its upper bit dropped
    wait_results_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cfg_write(rmed_pkg::CFG_FRAME_WIDTH, 13'd4095);
    cfg_write(rmed_pkg::CFG_FRAME_HEIGHT, 13'd0);
    send_stream(EDGE_ITEMS, 0, 1'b1);
    wait_results_drained();
    cfg_write(rmed_pkg::CFG_FRAME_WIDTH, 13'h1003);
    cfg_write(rmed_pkg::CFG_FRAME_HEIGHT, 13'h1fff);
    send_stream(EDGE_ITEMS, 0, 1'b1);

    wait_results_drained();
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

### files.f
design/rmed_pkg.sv
design/rmed_ram.sv
design/rmed_sort_cell.sv
design/rgb_median_3x3_centre_excluded_core.sv
sim/rgb_median_3x3_centre_excluded_core_tb.sv
